FILE: rtl/astrip_pkg.sv
package astrip_pkg;

  typedef enum logic [4:0] {
    POS_OUTSIDE       = 5'b00001,
    POS_AFTER_ESC     = 5'b00010,
    POS_AFTER_BRACKET = 5'b00100,
    POS_SKIP_ONE      = 5'b01000,
    POS_SKIP_TO_END   = 5'b10000
  } pos_t;

  typedef struct packed {
    pos_t pos_next;
    logic keep;
  } step_t;

  localparam logic [7:0] BYTE_ESC      = 8'h1B;
  localparam logic [7:0] BYTE_CSI      = 8'h9B;
  localparam logic [7:0] BYTE_LBRACKET = 8'h5B;
  localparam logic [7:0] BYTE_RBRACKET = 8'h5D;

  // NUL VT FF SO SI CAN SUB ESC DEL
  function automatic logic is_dropped_control(input logic [7:0] b);
    return b inside {8'h00, 8'h0B, 8'h0C, 8'h0E, 8'h0F, 8'h18, 8'h1A, 8'h1B, 8'h7F};
  endfunction

  // % # ( )
  function automatic logic is_charset_intro(input logic [7:0] b);
    return b inside {8'h25, 8'h23, 8'h28, 8'h29};
  endfunction

  // A-M P X a c d e f g h l m n q r s u ` ] ;
  function automatic logic is_terminator(input logic [7:0] b);
    return b inside {[8'h41:8'h4D], 8'h50, 8'h58, 8'h61, 8'h63, 8'h64, 8'h65,
                     8'h66, 8'h67, 8'h68, 8'h6C, 8'h6D, 8'h6E, 8'h71, 8'h72,
                     8'h73, 8'h75, 8'h60, 8'h5D, 8'h3B};
  endfunction

endpackage

FILE: rtl/astrip_if.sv
interface astrip_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface astrip_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;

  modport source (output valid, output out_byte, input ready);
  modport sink   (input valid, input out_byte, output ready);
endinterface

FILE: rtl/astrip_parser.sv
module astrip_parser (
  input  astrip_pkg::pos_t   pos,
  input  logic [7:0]         b,
  output astrip_pkg::step_t  step
);

  always_comb begin
    step.keep     = 1'b0;
    step.pos_next = astrip_pkg::POS_OUTSIDE;
    case (pos)
      astrip_pkg::POS_AFTER_ESC: begin
        if (b == astrip_pkg::BYTE_LBRACKET) begin
          step.pos_next = astrip_pkg::POS_AFTER_BRACKET;
        end else if (b == astrip_pkg::BYTE_RBRACKET) begin
          step.pos_next = astrip_pkg::POS_SKIP_TO_END;
        end else if (astrip_pkg::is_charset_intro(b)) begin
          step.pos_next = astrip_pkg::POS_SKIP_ONE;
        end
      end
      astrip_pkg::POS_AFTER_BRACKET: begin
        if (b == astrip_pkg::BYTE_LBRACKET) begin
          step.pos_next = astrip_pkg::POS_SKIP_ONE;
        end else if (!astrip_pkg::is_terminator(b)) begin
          step.pos_next = astrip_pkg::POS_SKIP_TO_END;
        end
      end
      astrip_pkg::POS_SKIP_ONE: begin
        step.pos_next = astrip_pkg::POS_OUTSIDE;
      end
      astrip_pkg::POS_SKIP_TO_END: begin
        if (!astrip_pkg::is_terminator(b)) begin
          step.pos_next = astrip_pkg::POS_SKIP_TO_END;
        end
      end
      default: begin
        // outside any sequence
        if (b == astrip_pkg::BYTE_ESC) begin
          step.pos_next = astrip_pkg::POS_AFTER_ESC;
        end else if (b == astrip_pkg::BYTE_CSI) begin
          step.pos_next = astrip_pkg::POS_AFTER_BRACKET;
        end else begin
          step.keep = !astrip_pkg::is_dropped_control(b);
        end
      end
    endcase
  end

endmodule

FILE: rtl/astrip_skid.sv
module astrip_skid (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [7:0]          push_byte,
  output logic                ready,
  astrip_out_if.source        text
);

  logic       main_valid;
  logic       skid_valid;
  logic [7:0] main_byte;
  logic [7:0] skid_byte;
  logic       pop;

  assign pop        = main_valid && text.ready;
  assign ready      = !skid_valid;
  assign text.valid = main_valid;
  assign text.out_byte = main_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || pop) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid || pop) begin
      main_byte <= skid_valid ? skid_byte : push_byte;
    end else if (push) begin
      skid_byte <= push_byte;
    end
  end

  a_skid_needs_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid holds an item while the main register is empty");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    main_valid && !text.ready |=> main_valid && $stable(main_byte))
    else $error("stalled item changed or vanished");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    main_valid && !text.ready && push |=> skid_valid)
    else $error("item pushed into a stalled stage was lost");

endmodule

FILE: rtl/ansi_escape_stripper_core.sv
// Strips ANSI/VT escape and control sequences from a terminal byte stream.
// One byte is taken per cycle while the output stage has a free entry, and a
// kept byte is registered there; stripped bytes produce nothing. The
// parser position is a one-hot register updated by a small next-state lookup
// on each accepted byte, and a two-entry output stage lets input keep flowing
// for one more kept byte while the output is stalled.
module ansi_escape_stripper_core (
  input  logic          clk,
  input  logic          rst,
  astrip_in_if.sink     raw,
  astrip_out_if.source  text
);

  astrip_pkg::pos_t  pos;
  astrip_pkg::step_t step;
  logic              accept;
  logic              stage_ready;

  assign raw.ready = stage_ready;
  assign accept    = raw.valid && stage_ready;

  astrip_parser u_parser (
    .pos  (pos),
    .b    (raw.in_byte),
    .step (step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= astrip_pkg::POS_OUTSIDE;
    end else if (accept) begin
      pos <= step.pos_next;
    end
  end

  astrip_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && step.keep),
    .push_byte (raw.in_byte),
    .ready     (stage_ready),
    .text      (text)
  );

  a_pos_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(pos))
    else $error("parser position not one-hot");

  a_esc_opens: assert property (@(posedge clk) disable iff (rst)
    accept && pos == astrip_pkg::POS_OUTSIDE && raw.in_byte == astrip_pkg::BYTE_ESC
    |=> pos == astrip_pkg::POS_AFTER_ESC)
    else $error("ESC outside a sequence did not open one");

  a_skip_one_closes: assert property (@(posedge clk) disable iff (rst)
    accept && pos == astrip_pkg::POS_SKIP_ONE |=> pos == astrip_pkg::POS_OUTSIDE)
    else $error("single skipped byte did not close the sequence");

  a_keep_only_outside: assert property (@(posedge clk) disable iff (rst)
    accept && step.keep |-> pos == astrip_pkg::POS_OUTSIDE)
    else $error("byte kept inside a sequence");

endmodule

FILE: dv/tb_ansi_escape_stripper_core.sv
module tb_ansi_escape_stripper_core;

  localparam string TERMINATORS = "ABCDEFGHIJKLMPXacdefghlmnqrsu`];";
  localparam string CHARSET_INTROS = "%#()";
  localparam string PARAM_CHARS = "0123456789?<=>:";

  logic clk = 1'b0;
  logic rst = 1'b1;

  astrip_in_if  raw_if ();
  astrip_out_if text_if ();

  ansi_escape_stripper_core DUT (
    .clk  (clk),
    .rst  (rst),
    .raw  (raw_if),
    .text (text_if)
  );

  always #2 clk = ~clk;

  // parser position and kept bytes still due on the output
  astrip_pkg::pos_t parse_pos = astrip_pkg::POS_OUTSIDE;
  logic [7:0]       kept_q[$];

  int bytes_sent = 0;
  int seqs_sent = 0;
  int kept_checked = 0;
  int fail_count = 0;
  int burst_left = 0;
  int rx_cycle = 0;

  function automatic logic ends_sequence(input logic [7:0] b);
    for (int i = 0; i < TERMINATORS.len(); i++)
      if (b == TERMINATORS[i]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic opens_charset(input logic [7:0] b);
    for (int i = 0; i < CHARSET_INTROS.len(); i++)
      if (b == CHARSET_INTROS[i]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic silent_control(input logic [7:0] b);
    case (b)
      8'h00, 8'h0B, 8'h0C, 8'h0E, 8'h0F, 8'h18, 8'h1A, 8'h7F: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic astrip_pkg::step_t strip_step(input astrip_pkg::pos_t p,
                                                   input logic [7:0] b);
    astrip_pkg::step_t s;
    s.keep = 1'b0;
    s.pos_next = astrip_pkg::POS_OUTSIDE;
    case (p)
      astrip_pkg::POS_AFTER_ESC: begin
        if (b == astrip_pkg::BYTE_LBRACKET) s.pos_next = astrip_pkg::POS_AFTER_BRACKET;
        else if (b == astrip_pkg::BYTE_RBRACKET) s.pos_next = astrip_pkg::POS_SKIP_TO_END;
        else if (opens_charset(b)) s.pos_next = astrip_pkg::POS_SKIP_ONE;
      end
      astrip_pkg::POS_AFTER_BRACKET: begin
        if (b == astrip_pkg::BYTE_LBRACKET) s.pos_next = astrip_pkg::POS_SKIP_ONE;
        else if (!ends_sequence(b)) s.pos_next = astrip_pkg::POS_SKIP_TO_END;
      end
      astrip_pkg::POS_SKIP_ONE: s.pos_next = astrip_pkg::POS_OUTSIDE;
      astrip_pkg::POS_SKIP_TO_END: begin
        if (!ends_sequence(b)) s.pos_next = astrip_pkg::POS_SKIP_TO_END;
      end
      default: begin
        if (b == astrip_pkg::BYTE_ESC) s.pos_next = astrip_pkg::POS_AFTER_ESC;
        else if (b == astrip_pkg::BYTE_CSI) s.pos_next = astrip_pkg::POS_AFTER_BRACKET;
        else s.keep = !silent_control(b);
      end
    endcase
    return s;
  endfunction

  // input side predicted before output side is checked, so same-edge order is moot
  always @(posedge clk) begin
    astrip_pkg::step_t s;
    logic [7:0] want;
    if (rst) begin
      parse_pos = astrip_pkg::POS_OUTSIDE;
      kept_q.delete();
    end else begin
      if (raw_if.valid && raw_if.ready) begin
        s = strip_step(parse_pos, raw_if.in_byte);
        parse_pos = s.pos_next;
        if (s.keep) kept_q.insert(kept_q.size(), raw_if.in_byte);
      end
      if (text_if.valid && text_if.ready) begin
        if (kept_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected out_byte %02h, nothing due", text_if.out_byte);
        end else begin
          want = kept_q[0];
          kept_q.delete(0);
          kept_checked++;
          if (text_if.out_byte !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("out_byte mismatch: expected %02h, got %02h", want,
                       text_if.out_byte);
          end
        end
      end
    end
  end

  // receiver: rotating stall pattern, including stretches with no stalls
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    case ((rx_cycle / 64) % 4)
      0: text_if.ready <= 1'b1;
      1: text_if.ready <= ($urandom_range(0, 1) == 1);
      2: text_if.ready <= (rx_cycle % 5 == 0);
      default: text_if.ready <= ($urandom_range(0, 4) != 0);
    endcase
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 7);
      raw_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 24);
    end
    raw_if.valid <= 1'b1;
    raw_if.in_byte <= b;
    @(posedge clk);
    while (!raw_if.ready) @(posedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_params;
    int n;
    n = $urandom_range(0, 4);
    repeat (n) send_byte(PARAM_CHARS[$urandom_range(0, PARAM_CHARS.len() - 1)]);
  endtask

  task automatic send_terminator;
    send_byte(TERMINATORS[$urandom_range(0, TERMINATORS.len() - 1)]);
  endtask

  task automatic test_control_bytes;
    // dropped controls, byte extremes and high bytes that pass through
    send_byte(8'h00);
    send_byte(8'h0B);
    send_byte(8'h0C);
    send_byte(8'h0E);
    send_byte(8'h0F);
    send_byte(8'h18);
    send_byte(8'h1A);
    send_byte(8'h7F);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h41);
  endtask

  task automatic test_escape_forms;
    // ESC [ K ends at the letter right after the bracket
    send_byte(astrip_pkg::BYTE_ESC); send_byte(astrip_pkg::BYTE_LBRACKET); send_byte("K");
    // OSC skips to its terminator
    send_byte(astrip_pkg::BYTE_ESC); send_byte(astrip_pkg::BYTE_RBRACKET);
    send_byte("0"); send_byte(";");
    // charset form swallows one byte, even an ESC
    send_byte(astrip_pkg::BYTE_ESC); send_byte("("); send_byte(astrip_pkg::BYTE_ESC);
    send_byte("Z");
    // ESC [ [ swallows one more byte
    send_byte(astrip_pkg::BYTE_ESC); send_byte(astrip_pkg::BYTE_LBRACKET);
    send_byte(astrip_pkg::BYTE_LBRACKET);
    send_byte("A");
    // ESC ESC: the second one is swallowed as an ordinary byte, z is kept
    send_byte(astrip_pkg::BYTE_ESC); send_byte(astrip_pkg::BYTE_ESC); send_byte("z");
    seqs_sent += 5;
  endtask

  task automatic test_csi_and_nul;
    // single-byte CSI with NUL inside, NUL right after ESC
    send_byte(astrip_pkg::BYTE_CSI); send_byte(8'h00); send_byte("m");
    send_byte(astrip_pkg::BYTE_ESC); send_byte(8'h00); send_byte("!");
    seqs_sent += 2;
  endtask

  task automatic test_random_stream(input int n_items);
    int start;
    int n;
    start = bytes_sent;
    while (bytes_sent - start < n_items) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          n = $urandom_range(1, 6);
          repeat (n) send_byte(8'($urandom_range(8'h20, 8'h7E)));
        end
        2, 3: begin
          send_byte(astrip_pkg::BYTE_ESC); send_byte(astrip_pkg::BYTE_LBRACKET);
          send_params(); send_terminator(); seqs_sent++;
        end
        4: begin
          send_byte(astrip_pkg::BYTE_CSI); send_params(); send_terminator(); seqs_sent++;
        end
        5: begin
          send_byte(astrip_pkg::BYTE_ESC); send_byte(astrip_pkg::BYTE_RBRACKET);
          n = $urandom_range(0, 3);
          repeat (n) send_byte(8'($urandom_range(0, 255)));
          send_terminator(); seqs_sent++;
        end
        6: begin
          send_byte(astrip_pkg::BYTE_ESC);
          send_byte(CHARSET_INTROS[$urandom_range(0, CHARSET_INTROS.len() - 1)]);
          send_byte(8'($urandom_range(0, 255))); seqs_sent++;
        end
        7: begin
          send_byte(astrip_pkg::BYTE_ESC); send_byte(8'($urandom_range(0, 255)));
          seqs_sent++;
        end
        8: begin
          send_byte(astrip_pkg::BYTE_ESC); send_byte(astrip_pkg::BYTE_LBRACKET);
          send_byte(astrip_pkg::BYTE_LBRACKET);
          send_byte(8'($urandom_range(0, 255))); seqs_sent++;
        end
        default: begin
          // noise, possibly cutting a sequence short
          n = $urandom_range(1, 4);
          repeat (n) send_byte(8'($urandom_range(0, 255)));
        end
      endcase
    end
  endtask

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int waited;
    raw_if.valid = 1'b0;
    raw_if.in_byte = 8'h00;
    text_if.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_control_bytes();
    test_escape_forms();
    test_csi_and_nul();
    test_random_stream(400);
    raw_if.valid <= 1'b0;

    waited = 0;
    while (kept_q.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (kept_q.size() != 0) begin
      fail_count += kept_q.size();
      $display("%0d kept bytes never appeared", kept_q.size());
    end

    $display("%0d bytes sent, %0d escape/control sequences, %0d kept bytes checked",
             bytes_sent, seqs_sent, kept_checked);
    $display("%0d failures (input bursts and output stalls throughout)", fail_count);
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
